// ----- hw/rtl/mfpp_pkg.sv -----
// Shared types, codes and constants of the monochrome framebuffer pixel packer.
package mfpp_pkg;

   // Default panel geometry in pixels.
   localparam int PANEL_WIDTH_DEF  = 400;
   localparam int PANEL_HEIGHT_DEF = 300;

   // Field widths fixed by the interface.
   localparam int MODE_W   = 2;
   localparam int PIXEL_W  = 16;
   localparam int COORD_W  = 9;
   localparam int BYTE_W   = 14;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 8;
   localparam int CSR_IDX_W = 2;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_PIX_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PIX_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BYTE_READ = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STAT_WRITTEN = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DROPPED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_READ    = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_X_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_START = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_END   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_END   = 2'd3;

   // Configuration reset values.
   localparam logic [COORD_W-1:0] X_END_RST = 9'd399;
   localparam logic [COORD_W-1:0] Y_END_RST = 9'd299;

   // Pixels below this value are black.
   localparam logic [PIXEL_W-1:0] BLACK_LIMIT = 16'h7fff;
   // Mask of the leftmost bit within a byte.
   localparam logic [DATA_W-1:0]  TOP_BIT     = 8'h80;

   // What the memory stage does with an item.
   typedef enum logic [1:0] {
      OP_WRITE,
      OP_RD_PIX,
      OP_RD_BYTE,
      OP_NONE
   } op_type;

endpackage

// ----- hw/rtl/mfpp_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
module mfpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mono_framebuffer_pixel_packer.sv -----
// Top level of the monochrome framebuffer pixel packer: RGB565 in, 1-bit framebuffer.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------------
//   req_    | in        | req_valid / req_stall  | mode, pixel_value, read_x, read_y, byte_index
//   rsp_    | out       | rsp_valid / rsp_stall  | status, read_data, window_last
//   csr_    | in        | csr_valid / csr_ready  | index, wdata (window registers)
//
// One request is taken per cycle while req_stall is low. Each request goes through two
// stages: the address stage computes the byte address and issues the framebuffer read,
// the memory stage merges a written pixel into the returned byte and writes it back or
// picks out the read data; the item is held in the memory stage register and its result
// in the response register. The separate read and write ports of the framebuffer RAM,
// with the last write forwarded, keep that rate. Synchronous reset clears control state
// and moves the scan position to the window start; the framebuffer is not cleared. When
// the response register is full and stalled, the memory stage holds and req_stall rises.
module mono_framebuffer_pixel_packer #(
   parameter int PANEL_WIDTH  = mfpp_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = mfpp_pkg::PANEL_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mfpp_pkg::MODE_W-1:0]      req_mode,
   input  logic [mfpp_pkg::PIXEL_W-1:0]     req_pixel_value,
   input  logic [mfpp_pkg::COORD_W-1:0]     req_read_x,
   input  logic [mfpp_pkg::COORD_W-1:0]     req_read_y,
   input  logic [mfpp_pkg::BYTE_W-1:0]      req_byte_index,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mfpp_pkg::STATUS_W-1:0]    rsp_status,
   output logic [mfpp_pkg::DATA_W-1:0]      rsp_read_data,
   output logic                             rsp_window_last,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mfpp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mfpp_pkg::COORD_W-1:0]     csr_wdata
);

   import mfpp_pkg::*;

   // Framebuffer geometry.
   localparam int FB_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 8;
   localparam int ADDR_W   = $clog2(FB_BYTES);
   localparam int HQ       = PANEL_HEIGHT / 4;
   localparam int HQ_W     = $clog2(HQ + 1);
   // Address arithmetic width: holds the product, the byte index and the framebuffer size.
   localparam int PROD_W   = (COORD_W - 1) + HQ_W + 1;
   localparam int CALC_A   = (PROD_W > ADDR_W + 1) ? PROD_W : ADDR_W + 1;
   localparam int CALC_B   = (CALC_A > BYTE_W + 1) ? CALC_A : BYTE_W + 1;
   localparam int CALC_W   = (CALC_B > COORD_W + 2) ? CALC_B : COORD_W + 2;

   // ------------------------------------------------------------------
   // Window registers and scan position.
   // ------------------------------------------------------------------
   logic [COORD_W-1:0] x_start_ff, y_start_ff, x_end_ff, y_end_ff;
   logic [COORD_W-1:0] cur_col_ff, cur_col_in;
   logic [COORD_W-1:0] cur_row_ff, cur_row_in;
   logic [COORD_W-1:0] x_end_clamp, y_end_clamp;
   logic               win_empty;
   logic               csr_fire;
   logic               req_fire;
   logic               pix_write;
   logic               scan_last;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   // The window end never runs past the panel edge.
   assign x_end_clamp = (int'(x_end_ff) > PANEL_WIDTH - 1)  ? COORD_W'(PANEL_WIDTH - 1)
                                                             : x_end_ff;
   assign y_end_clamp = (int'(y_end_ff) > PANEL_HEIGHT - 1) ? COORD_W'(PANEL_HEIGHT - 1)
                                                             : y_end_ff;
   assign win_empty   = (x_start_ff > x_end_clamp) || (y_start_ff > y_end_clamp);

   assign pix_write = req_fire && (req_mode == MODE_PIX_WRITE) && !win_empty;
   assign scan_last = (cur_col_ff >= x_end_clamp) && (cur_row_ff >= y_end_clamp);

   // Raster advance: left to right, then down, wrapping to the window start.
   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      if (pix_write) begin
         if (cur_col_ff >= x_end_clamp) begin
            cur_col_in = x_start_ff;
            if (cur_row_ff >= y_end_clamp) begin
               cur_row_in = y_start_ff;
            end else begin
               cur_row_in = cur_row_ff + COORD_W'(1);
            end
         end else begin
            cur_col_in = cur_col_ff + COORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_start_ff <= '0;
         y_start_ff <= '0;
         x_end_ff   <= X_END_RST;
         y_end_ff   <= Y_END_RST;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
      end else if (csr_fire) begin
         // Any register write restarts the scan at the (new) window start.
         case (csr_index)
            CSR_X_START: begin
               x_start_ff <= csr_wdata;
               cur_col_ff <= csr_wdata;
               cur_row_ff <= y_start_ff;
            end
            CSR_Y_START: begin
               y_start_ff <= csr_wdata;
               cur_col_ff <= x_start_ff;
               cur_row_ff <= csr_wdata;
            end
            CSR_X_END: begin
               x_end_ff   <= csr_wdata;
               cur_col_ff <= x_start_ff;
               cur_row_ff <= y_start_ff;
            end
            CSR_Y_END: begin
               y_end_ff   <= csr_wdata;
               cur_col_ff <= x_start_ff;
               cur_row_ff <= y_start_ff;
            end
            default: begin
               cur_col_ff <= x_start_ff;
               cur_row_ff <= y_start_ff;
            end
         endcase
      end else begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
      end
   end

   // ------------------------------------------------------------------
   // Address stage: one shared address path for writes and pixel reads.
   // ------------------------------------------------------------------
   logic [COORD_W-1:0] pix_x, pix_y;
   logic [CALC_W-1:0]  inv_y;
   logic [CALC_W-1:0]  pix_addr;
   logic [CALC_W-1:0]  byte_addr;
   logic [CALC_W-1:0]  sel_addr;
   logic               coord_ok;
   logic               addr_ok;
   logic [DATA_W-1:0]  pix_mask;
   op_type             a_op;
   logic [STATUS_W-1:0] a_status;

   always_comb begin
      if (req_mode == MODE_PIX_WRITE) begin
         pix_x    = cur_col_ff;
         pix_y    = cur_row_ff;
         coord_ok = 1'b1;
      end else begin
         pix_x    = req_read_x;
         pix_y    = req_read_y;
         // Only a pixel read is bounded by the panel; a byte read checks its index alone.
         coord_ok = (req_mode != MODE_PIX_READ) ||
                    ((int'(req_read_x) < PANEL_WIDTH) && (int'(req_read_y) < PANEL_HEIGHT));
      end
   end

   // Rows run bottom-up inside a column pair; four rows share a byte.
   assign inv_y    = CALC_W'(PANEL_HEIGHT - 1) - CALC_W'(pix_y);
   assign pix_addr = CALC_W'(pix_x[COORD_W-1:1]) * CALC_W'(HQ) + (inv_y >> 2);
   assign pix_mask = TOP_BIT >> {inv_y[1:0], pix_x[0]};
   assign byte_addr = CALC_W'(req_byte_index);

   always_comb begin
      a_status = STAT_READ;
      a_op     = OP_NONE;
      sel_addr = pix_addr;
      case (req_mode)
         MODE_PIX_WRITE: begin
            a_status = win_empty ? STAT_DROPPED : STAT_WRITTEN;
            a_op     = win_empty ? OP_NONE : OP_WRITE;
         end
         MODE_PIX_READ: begin
            a_op = OP_RD_PIX;
         end
         MODE_BYTE_READ: begin
            a_op     = OP_RD_BYTE;
            sel_addr = byte_addr;
         end
         default: begin
            a_op = OP_NONE;
         end
      endcase
   end

   assign addr_ok = coord_ok && (sel_addr < CALC_W'(FB_BYTES));

   // ------------------------------------------------------------------
   // Memory stage registers and handshake.
   // ------------------------------------------------------------------
   logic                s1_valid_ff;
   op_type              s1_op_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic                s1_ok_ff;
   logic [DATA_W-1:0]   s1_mask_ff;
   logic                s1_set_ff;
   logic [STATUS_W-1:0] s1_status_ff;
   logic                s1_last_ff;
   logic                s1_adv;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0]   rsp_data_ff;
   logic                rsp_last_ff;

   // The memory stage moves on when the response register is free or being taken.
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_fire  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff     <= a_op;
         s1_addr_ff   <= sel_addr[ADDR_W-1:0];
         s1_ok_ff     <= addr_ok;
         s1_mask_ff   <= pix_mask;
         s1_set_ff    <= !(req_pixel_value < BLACK_LIMIT);
         s1_status_ff <= a_status;
         s1_last_ff   <= pix_write && scan_last;
      end
   end

   // ------------------------------------------------------------------
   // Framebuffer memory with forwarding of the most recent write.
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] ram_q;
   logic [DATA_W-1:0] cur_byte;
   logic [DATA_W-1:0] new_byte;
   logic              ram_we;
   logic              wb_valid_ff;
   logic [ADDR_W-1:0] wb_addr_ff;
   logic [DATA_W-1:0] wb_data_ff;

   mfpp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (FB_BYTES)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_addr_ff),
      .wr_data (new_byte),
      .rd_en   (req_fire),
      .rd_addr (sel_addr[ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   // The RAM returns old data when a read meets a write to the same byte in one cycle.
   // The last write is always the newest value of its byte, so it can be forwarded
   // whenever the addresses match.
   assign cur_byte = (wb_valid_ff && (wb_addr_ff == s1_addr_ff)) ? wb_data_ff : ram_q;
   assign new_byte = s1_set_ff ? (cur_byte | s1_mask_ff) : (cur_byte & ~s1_mask_ff);
   assign ram_we   = s1_adv && (s1_op_ff == OP_WRITE) && s1_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else if (ram_we) begin
         wb_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         wb_addr_ff <= s1_addr_ff;
         wb_data_ff <= new_byte;
      end
   end

   // ------------------------------------------------------------------
   // Response register.
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] s1_data;

   always_comb begin
      case (s1_op_ff)
         OP_RD_PIX:  s1_data = DATA_W'(s1_ok_ff && ((cur_byte & s1_mask_ff) == '0));
         OP_RD_BYTE: s1_data = s1_ok_ff ? cur_byte : '0;
         default:    s1_data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_status_ff <= s1_status_ff;
         rsp_data_ff   <= s1_data;
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_window_last = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_stall_needs_busy_stage: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a blocked memory stage");

   a_write_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (s1_valid_ff && s1_adv))
      else $error("framebuffer written by an item that is not leaving the stage");

   a_scan_inside_window: assert property (@(posedge clock) disable iff (reset)
      !win_empty |-> ((cur_col_ff <= x_end_clamp) && (cur_row_ff <= y_end_clamp)))
      else $error("scan position outside the window");

   a_held_stage_keeps_item: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_addr_ff)))
      else $error("memory stage lost its item while blocked");

endmodule
